[hdl/ffha_pkg.sv]
// Shared types, codes and defaults of the first-fit heap allocator.
package ffha_pkg;

	localparam int HEADER_BYTES_DEF  = 24;
	localparam int FREE_SEGMENTS_DEF = 64;
	localparam int LIVE_BLOCKS_DEF   = 64;
	localparam int HEAP_BYTES_DEF    = 65536;

	localparam logic [15:0] REGION_START_RST = 16'd8;
	localparam logic [15:0] REGION_BYTES_RST = 16'd65528;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_QUERY  = 2'd2,
		OP_REINIT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		CFG_REGION_START = 1'b0,
		CFG_REGION_BYTES = 1'b1
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_RST_INIT,
		S_IDLE,
		S_INIT,
		S_A_RD,
		S_A_CHK,
		S_A_SLOT,
		S_A_UPD,
		S_SHD_RD,
		S_SHD_WR,
		S_F_RD,
		S_F_CHK,
		S_P_RD,
		S_P_CHK,
		S_F_DEC,
		S_SHU_RD,
		S_SHU_WR,
		S_F_INS,
		S_L_START,
		S_L_RD,
		S_L_CHK,
		S_DONE
	} state_t;

endpackage

[hdl/ffha_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module ffha_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/first_fit_heap_allocator.sv]
// First-fit heap allocator. One operation at a time: an allocate scans the free-segment
// table and then the live-block valid bits, and may shift free entries down by one
// place; a free scans the live table and then the free table, and may shift free entries
// by one place. Every operation ends with a scan of the free table for the largest
// segment. After reset the block loads the region before it takes a request. Region
// registers take effect at reset and on a reinitialise.
module first_fit_heap_allocator #(
	parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
	parameter int FREE_SEGMENTS = ffha_pkg::FREE_SEGMENTS_DEF,
	parameter int LIVE_BLOCKS   = ffha_pkg::LIVE_BLOCKS_DEF,
	parameter int HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] request_bytes,
	input  logic [15:0] release_offset,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [15:0] granted_offset,
	output logic [1:0]  status,
	output logic [15:0] largest_payload
);
	import ffha_pkg::*;

	localparam int FW = $clog2(FREE_SEGMENTS);
	localparam int LW = $clog2(LIVE_BLOCKS);
	localparam logic [16:0] HDR = 17'(HEADER_BYTES);
	localparam logic [16:0] ADDR_END = (HEAP_BYTES < 65536) ? 17'(HEAP_BYTES) : 17'd65536;
	localparam logic [FW:0] FREE_N = (FW+1)'(FREE_SEGMENTS);
	localparam logic [LW:0] LIVE_N = (LW+1)'(LIVE_BLOCKS);

	state_t state_q, state_d;

	logic [15:0] rstart_q, rbytes_q;
	op_t         op_q;
	logic [15:0] off_q;
	logic [16:0] need_q;
	logic [FW:0] idx_q, sidx_q, cnt_q;
	logic [LW:0] slot_q, k_q;
	logic [15:0] bs_q, prev_s_q, cur_s_q;
	logic [16:0] blen_q, seglen_q, prev_l_q, cur_l_q, best_q;
	status_t     st_q;
	logic [15:0] grant_q;
	logic [LIVE_BLOCKS-1:0] valid_q;
	logic        rsp_valid_q;
	logic [15:0] out_grant_q, out_large_q;
	logic [1:0]  out_st_q;

	// free table ram
	logic          fwe;
	logic [FW-1:0] fwaddr, fraddr;
	logic [32:0]   fwdata, frdata;
	logic [15:0]   frs;
	logic [16:0]   frl;
	// live table ram
	logic          lwe;
	logic [32:0]   lrdata;
	logic [15:0]   lrs;
	logic [16:0]   lrl;

	// derived values
	logic [16:0] region_len, lim_len;
	logic [16:0] rem, alloc_blen, be, prev_end;
	logic        split_no, mp, ms, okmatch;

	assign frs = frdata[32:17];
	assign frl = frdata[16:0];
	assign lrs = lrdata[32:17];
	assign lrl = lrdata[16:0];

	ffha_ram #(.WIDTH(33), .DEPTH(FREE_SEGMENTS)) u_free_ram (
		.clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata), .raddr(fraddr), .rdata(frdata)
	);

	ffha_ram #(.WIDTH(33), .DEPTH(LIVE_BLOCKS)) u_live_ram (
		.clk(clk), .we(lwe), .waddr(slot_q[LW-1:0]), .wdata({bs_q, alloc_blen}),
		.raddr(k_q[LW-1:0]), .rdata(lrdata)
	);

	always_comb begin
		lim_len = ADDR_END - {1'b0, rstart_q};
		region_len = 17'd0;
		if ({1'b0, rstart_q} < ADDR_END) begin
			region_len = ({1'b0, rbytes_q} < lim_len) ? {1'b0, rbytes_q} : lim_len;
		end
	end

	assign rem        = seglen_q - need_q;
	assign split_no   = rem < HDR;
	assign alloc_blen = split_no ? seglen_q : need_q;
	assign be         = {1'b0, bs_q} + blen_q;
	assign prev_end   = {1'b0, prev_s_q} + prev_l_q;
	assign mp         = (idx_q != '0) && (prev_end == {1'b0, bs_q});
	assign ms         = (idx_q < cnt_q) && ({1'b0, cur_s_q} == be);
	assign okmatch    = valid_q[k_q[LW-1:0]] && (({1'b0, lrs} + HDR) == {1'b0, off_q});

	assign req_ready       = (state_q == S_IDLE);
	assign rsp_valid       = rsp_valid_q;
	assign granted_offset  = out_grant_q;
	assign status          = out_st_q;
	assign largest_payload = out_large_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_RST_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (req_valid) begin
					case (op_t'(opcode))
						OP_ALLOC:  state_d = (request_bytes == '0) ? S_L_START : S_A_RD;
						OP_FREE:   state_d = (release_offset == '0) ? S_L_START : S_F_RD;
						OP_REINIT: state_d = S_INIT;
						default:   state_d = S_L_START;
					endcase
				end
			end
			S_INIT:   state_d = S_L_START;
			S_A_RD:   state_d = (idx_q >= cnt_q) ? S_L_START : S_A_CHK;
			S_A_CHK:  state_d = (frl >= need_q) ? S_A_SLOT : S_A_RD;
			S_A_SLOT: begin
				if (slot_q == LIVE_N) begin
					state_d = S_L_START;
				end else if (!valid_q[slot_q[LW-1:0]]) begin
					state_d = S_A_UPD;
				end
			end
			S_A_UPD:  state_d = split_no ? S_SHD_RD : S_L_START;
			S_SHD_RD: state_d = ((idx_q + 1'b1) < cnt_q) ? S_SHD_WR : S_L_START;
			S_SHD_WR: state_d = S_SHD_RD;
			S_F_RD:   state_d = (k_q == LIVE_N) ? S_L_START : S_F_CHK;
			S_F_CHK:  state_d = okmatch ? S_P_RD : S_F_RD;
			S_P_RD:   state_d = (idx_q >= cnt_q) ? S_F_DEC : S_P_CHK;
			S_P_CHK:  state_d = (frs > bs_q) ? S_F_DEC : S_P_RD;
			S_F_DEC: begin
				if (mp && ms) begin
					state_d = S_SHD_RD;
				end else if (mp || ms || cnt_q >= FREE_N) begin
					state_d = S_L_START;
				end else begin
					state_d = S_SHU_RD;
				end
			end
			S_SHU_RD:  state_d = (sidx_q > idx_q) ? S_SHU_WR : S_F_INS;
			S_SHU_WR:  state_d = S_SHU_RD;
			S_F_INS:   state_d = S_L_START;
			S_L_START: state_d = S_L_RD;
			S_L_RD:    state_d = (idx_q >= cnt_q) ? S_DONE : S_L_CHK;
			S_L_CHK:   state_d = S_L_RD;
			S_DONE:    state_d = (!rsp_valid_q || rsp_ready) ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		fwe    = 1'b0;
		fwaddr = idx_q[FW-1:0];
		fwdata = {bs_q, blen_q};
		fraddr = idx_q[FW-1:0];
		lwe    = 1'b0;
		case (state_q)
			S_RST_INIT, S_INIT: begin
				fwe    = 1'b1;
				fwaddr = '0;
				fwdata = {rstart_q, region_len};
			end
			S_A_UPD: begin
				lwe = 1'b1;
				if (!split_no) begin
					fwe    = 1'b1;
					fwdata = {bs_q + need_q[15:0], rem};
				end
			end
			S_SHD_RD: fraddr = FW'(idx_q + 1'b1);
			S_SHD_WR: begin
				fwe    = 1'b1;
				fwdata = frdata;
			end
			S_F_DEC: begin
				if (mp) begin
					fwe    = 1'b1;
					fwaddr = FW'(idx_q - 1'b1);
					fwdata = {prev_s_q, ms ? (prev_l_q + blen_q + cur_l_q) : (prev_l_q + blen_q)};
				end else if (ms) begin
					fwe    = 1'b1;
					fwdata = {bs_q, cur_l_q + blen_q};
				end
			end
			S_SHU_RD: fraddr = FW'(sidx_q - 1'b1);
			S_SHU_WR: begin
				fwe    = 1'b1;
				fwaddr = sidx_q[FW-1:0];
				fwdata = frdata;
			end
			S_F_INS: fwe = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RST_INIT;
			rstart_q    <= REGION_START_RST;
			rbytes_q    <= REGION_BYTES_RST;
			valid_q     <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_REGION_START: rstart_q <= cfg_data;
					CFG_REGION_BYTES: rbytes_q <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_RST_INIT, S_INIT: begin
					cnt_q   <= (region_len != '0) ? (FW+1)'(1) : '0;
					valid_q <= '0;
				end
				S_A_UPD: begin
					valid_q[slot_q[LW-1:0]] <= 1'b1;
				end
				S_SHD_RD: begin
					if ((idx_q + 1'b1) >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_F_DEC: begin
					if (mp || ms || cnt_q < FREE_N) begin
						valid_q[k_q[LW-1:0]] <= 1'b0;
					end
				end
				S_F_INS: cnt_q <= cnt_q + 1'b1;
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
					end else begin
						rsp_valid_q <= rsp_valid_q;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= op_t'(opcode);
				off_q   <= release_offset;
				need_q  <= {1'b0, request_bytes} + HDR;
				idx_q   <= '0;
				k_q     <= '0;
				slot_q  <= '0;
				grant_q <= '0;
				st_q    <= (op_t'(opcode) == OP_ALLOC && request_bytes == '0) ? ST_NOFIT : ST_OK;
			end
			S_A_RD: begin
				if (idx_q >= cnt_q) begin
					st_q <= ST_NOFIT;
				end
			end
			S_A_CHK: begin
				if (frl >= need_q) begin
					bs_q     <= frs;
					seglen_q <= frl;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_A_SLOT: begin
				if (slot_q == LIVE_N) begin
					st_q <= ST_FULL;
				end else if (valid_q[slot_q[LW-1:0]]) begin
					slot_q <= slot_q + 1'b1;
				end
			end
			S_A_UPD: grant_q <= bs_q + HDR[15:0];
			S_SHD_WR: idx_q <= idx_q + 1'b1;
			S_F_RD: begin
				if (k_q == LIVE_N) begin
					st_q <= ST_UNKNOWN;
				end
			end
			S_F_CHK: begin
				if (okmatch) begin
					bs_q   <= lrs;
					blen_q <= lrl;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			S_P_CHK: begin
				cur_s_q <= frs;
				cur_l_q <= frl;
				if (frs <= bs_q) begin
					prev_s_q <= frs;
					prev_l_q <= frl;
					idx_q    <= idx_q + 1'b1;
				end
			end
			S_F_DEC: begin
				sidx_q <= cnt_q;
				if (!mp && !ms && cnt_q >= FREE_N) begin
					st_q <= ST_FULL;
				end
			end
			S_SHU_WR: sidx_q <= sidx_q - 1'b1;
			S_L_START: begin
				idx_q  <= '0;
				best_q <= '0;
			end
			S_L_CHK: begin
				if (frl > best_q) begin
					best_q <= frl;
				end
				idx_q <= idx_q + 1'b1;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_grant_q <= (op_q == OP_ALLOC && st_q == ST_OK) ? grant_q : '0;
					out_st_q    <= st_q;
					if (best_q <= HDR) begin
						out_large_q <= '0;
					end else if ((best_q - HDR) > 17'h0FFFF) begin
						out_large_q <= 16'hFFFF;
					end else begin
						out_large_q <= 16'(best_q - HDR);
					end
				end
			end
			default: ;
		endcase
	end
endmodule

[test/tb_first_fit_heap_allocator.sv]
// Self-checking testbench for the first-fit heap allocator: directed and random operations.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int HDR   = HEADER_BYTES_DEF;
	localparam int NSEG  = FREE_SEGMENTS_DEF;
	localparam int NLIVE = LIVE_BLOCKS_DEF;
	localparam int ADDR_END = (HEAP_BYTES_DEF < 65536) ? HEAP_BYTES_DEF : 65536;

	typedef struct packed {
		logic [15:0] offset;
		status_t     st;
		logic [15:0] largest;
	} heap_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  opcode;
	logic [15:0] request_bytes;
	logic [15:0] release_offset;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [15:0] granted_offset;
	logic [1:0]  status;
	logic [15:0] largest_payload;

	first_fit_heap_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready),
		.opcode(opcode), .request_bytes(request_bytes), .release_offset(release_offset),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.granted_offset(granted_offset), .status(status), .largest_payload(largest_payload)
	);

	// shadow heap state
	int unsigned reg_start, reg_bytes;
	int unsigned seg_start [NSEG];
	int unsigned seg_len [NSEG];
	int unsigned seg_count;
	int unsigned blk_start [NLIVE];
	int unsigned blk_len [NLIVE];
	bit          blk_live [NLIVE];

	heap_rsp_t pending_rsp[$];
	int        mismatches;
	int        send_idle_pct, recv_idle_pct;
	bit        recv_hold;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	function automatic void heap_load();
		int unsigned len;
		len = 0;
		if (reg_start < ADDR_END) begin
			len = ADDR_END - reg_start;
			if (reg_bytes < len) len = reg_bytes;
		end
		seg_count = 0;
		if (len != 0) begin
			seg_start[0] = reg_start;
			seg_len[0] = len;
			seg_count = 1;
		end
		foreach (blk_live[i]) blk_live[i] = 1'b0;
	endfunction

	function automatic void seg_drop(int unsigned pos);
		for (int unsigned i = pos; i + 1 < seg_count; i++) begin
			seg_start[i] = seg_start[i + 1];
			seg_len[i] = seg_len[i + 1];
		end
		seg_count--;
	endfunction

	function automatic logic [15:0] heap_largest();
		int unsigned best;
		best = 0;
		for (int unsigned i = 0; i < seg_count; i++)
			if (seg_len[i] > best) best = seg_len[i];
		if (best <= HDR) return 16'd0;
		best -= HDR;
		return (best > 16'hFFFF) ? 16'hFFFF : best[15:0];
	endfunction

	function automatic status_t heap_alloc(int unsigned req, output logic [15:0] off);
		int unsigned need, i, slot, bs, bl;
		off = 16'd0;
		if (req == 0) return ST_NOFIT;
		need = req + HDR;
		for (i = 0; i < seg_count; i++)
			if (seg_len[i] >= need) break;
		if (i >= seg_count) return ST_NOFIT;
		for (slot = 0; slot < NLIVE; slot++)
			if (!blk_live[slot]) break;
		if (slot >= NLIVE) return ST_FULL;
		bs = seg_start[i];
		if (seg_len[i] - need < HDR) begin
			bl = seg_len[i];
			seg_drop(i);
		end else begin
			bl = need;
			seg_start[i] = bs + need;
			seg_len[i] -= need;
		end
		blk_start[slot] = bs;
		blk_len[slot] = bl;
		blk_live[slot] = 1'b1;
		off = 16'((bs + HDR) & 16'hFFFF);
		return ST_OK;
	endfunction

	function automatic status_t heap_release(int unsigned off);
		int unsigned k, pos, bs, be;
		bit mp, ms;
		if (off == 0) return ST_OK;
		for (k = 0; k < NLIVE; k++)
			if (blk_live[k] && blk_start[k] + HDR == off) break;
		if (k >= NLIVE) return ST_UNKNOWN;
		bs = blk_start[k];
		be = bs + blk_len[k];
		for (pos = 0; pos < seg_count; pos++)
			if (seg_start[pos] > bs) break;
		mp = pos > 0 && seg_start[pos - 1] + seg_len[pos - 1] == bs;
		ms = pos < seg_count && seg_start[pos] == be;
		if (mp && ms) begin
			seg_len[pos - 1] += blk_len[k] + seg_len[pos];
			seg_drop(pos);
		end else if (mp) begin
			seg_len[pos - 1] += blk_len[k];
		end else if (ms) begin
			seg_start[pos] = bs;
			seg_len[pos] += blk_len[k];
		end else begin
			if (seg_count >= NSEG) return ST_FULL;
			for (int unsigned i = seg_count; i > pos; i--) begin
				seg_start[i] = seg_start[i - 1];
				seg_len[i] = seg_len[i - 1];
			end
			seg_start[pos] = bs;
			seg_len[pos] = blk_len[k];
			seg_count++;
		end
		blk_live[k] = 1'b0;
		return ST_OK;
	endfunction

	function automatic heap_rsp_t heap_predict(op_t op, logic [15:0] req, logic [15:0] off);
		heap_rsp_t r;
		logic [15:0] g;
		g = 16'd0;
		r.st = ST_OK;
		case (op)
			OP_ALLOC:  r.st = heap_alloc(req, g);
			OP_FREE:   r.st = heap_release(off);
			OP_REINIT: heap_load();
			default: ;
		endcase
		r.offset = g;
		r.largest = heap_largest();
		return r;
	endfunction

	// pick the offset of a random live block, or a random value if none is live
	function automatic logic [15:0] live_offset();
		int unsigned k;
		for (int n = 0; n < 8; n++) begin
			k = $urandom_range(NLIVE - 1);
			if (blk_live[k]) return 16'((blk_start[k] + HDR) & 16'hFFFF);
		end
		for (k = 0; k < NLIVE; k++)
			if (blk_live[k]) return 16'((blk_start[k] + HDR) & 16'hFFFF);
		return 16'($urandom);
	endfunction

	task automatic send_op(op_t op, logic [15:0] req, logic [15:0] off);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		req_valid <= 1'b1;
		opcode <= op;
		request_bytes <= req;
		release_offset <= off;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_rsp.push_back(heap_predict(op, req, off));
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (pending_rsp.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (500) @(posedge clk);
	endtask

	// registers are only written while no beat is in flight
	task automatic write_cfg(cfg_idx_t idx, logic [15:0] val);
		while (pending_rsp.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_REGION_START) reg_start = val;
		else reg_bytes = val;
		@(posedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		heap_rsp_t exp_r;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response beat");
			end else begin
				exp_r = pending_rsp.pop_front();
				if (granted_offset !== exp_r.offset || status !== exp_r.st ||
						largest_payload !== exp_r.largest) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp off %0d st %0d lg %0d, got off %0d st %0d lg %0d",
							exp_r.offset, exp_r.st, exp_r.largest,
							granted_offset, status, largest_payload);
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) rsp_ready <= 1'b0;
		else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic test_directed();
		logic [15:0] a, b, c;
		send_op(OP_QUERY, 16'd0, 16'd0);
		send_op(OP_ALLOC, 16'd0, 16'd0);
		send_op(OP_ALLOC, 16'hFFFF, 16'd0);
		send_op(OP_ALLOC, 16'd1, 16'd0);
		a = 16'(8 + HDR);
		send_op(OP_ALLOC, 16'd100, 16'd0);
		b = 16'(8 + 2 * HDR + 1);
		send_op(OP_ALLOC, 16'd50, 16'd0);
		c = 16'(8 + 3 * HDR + 101);
		send_op(OP_FREE, 16'd0, 16'd0);
		send_op(OP_FREE, 16'd0, 16'hFFFF);
		send_op(OP_FREE, 16'd0, 16'd12345);
		send_op(OP_FREE, 16'd0, b);
		send_op(OP_FREE, 16'd0, b);
		send_op(OP_FREE, 16'd0, a);
		send_op(OP_FREE, 16'd0, c);
		send_op(OP_ALLOC, 16'(65528 - HDR), 16'd0);
		send_op(OP_QUERY, 16'd0, 16'd0);
		send_op(OP_REINIT, 16'd0, 16'd0);
		// remainder of a header plus five bytes: segment is split
		send_op(OP_ALLOC, 16'(65528 - 2 * HDR - 5), 16'd0);
		send_op(OP_REINIT, 16'd0, 16'd0);
		drain();
	endtask

	// fill the live table, then free every other block to fragment the free table, then the rest
	task automatic test_tables_full();
		logic [15:0] offs [$];
		for (int i = 0; i < NLIVE + 2; i++) send_op(OP_ALLOC, 16'd8, 16'd0);
		send_op(OP_ALLOC, 16'hFFFF, 16'd0);
		for (int k = 0; k < NLIVE; k++)
			if (blk_live[k]) offs.push_back(16'(blk_start[k] + HDR));
		for (int i = 0; i < offs.size(); i += 2) send_op(OP_FREE, 16'd0, offs[i]);
		for (int i = 1; i < offs.size(); i += 2) send_op(OP_FREE, 16'd0, offs[i]);
		send_op(OP_REINIT, 16'd0, 16'd0);
		drain();
	endtask

	task automatic test_fragmented_free_full();
		logic [15:0] offs [$];
		// small region of one-byte allocations; isolated frees add entries to the free table
		write_cfg(CFG_REGION_BYTES, 16'(NLIVE * 2 * HDR - 1));
		send_op(OP_REINIT, 16'd0, 16'd0);
		for (int i = 0; i < NLIVE; i++) send_op(OP_ALLOC, 16'd1, 16'd0);
		for (int k = 0; k < NLIVE; k++)
			if (blk_live[k]) offs.push_back(16'(blk_start[k] + HDR));
		for (int i = 0; i < offs.size(); i += 2) send_op(OP_FREE, 16'd0, offs[i]);
		drain();
	endtask

	task automatic test_region_settings();
		write_cfg(CFG_REGION_START, 16'hFFFF);
		write_cfg(CFG_REGION_BYTES, 16'hFFFF);
		send_op(OP_REINIT, 16'd0, 16'd0);
		send_op(OP_ALLOC, 16'd1, 16'd0);
		write_cfg(CFG_REGION_START, 16'hFFE0);
		send_op(OP_REINIT, 16'd0, 16'd0);
		send_op(OP_ALLOC, 16'd1, 16'd0);
		send_op(OP_ALLOC, 16'd8, 16'd0);
		write_cfg(CFG_REGION_START, 16'd8);
		write_cfg(CFG_REGION_BYTES, 16'd0);
		send_op(OP_REINIT, 16'd0, 16'd0);
		send_op(OP_ALLOC, 16'd1, 16'd0);
		write_cfg(CFG_REGION_START, 16'h5555);
		write_cfg(CFG_REGION_BYTES, 16'h2AAA);
		send_op(OP_REINIT, 16'd0, 16'd0);
		send_op(OP_ALLOC, 16'h0800, 16'd0);
		drain();
	endtask

	task automatic test_random(int n);
		int unsigned r;
		logic [15:0] sz;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			sz = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(400));
			if (r < 45) send_op(OP_ALLOC, sz, 16'($urandom));
			else if (r < 85) send_op(OP_FREE, 16'($urandom), live_offset());
			else if (r < 92) send_op(OP_FREE, 16'($urandom), 16'($urandom));
			else if (r < 99) send_op(OP_QUERY, 16'($urandom), 16'($urandom));
			else send_op(OP_REINIT, 16'($urandom), 16'($urandom));
		end
		drain();
	endtask

	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1'b1;
				repeat (3000) @(posedge clk);
				recv_hold = 1'b0;
			end
			for (int i = 0; i < 20; i++) send_op(OP_ALLOC, 16'd16, 16'd0);
		join
		drain();
	endtask

	initial begin
		cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
		req_valid = 1'b0; opcode = '0; request_bytes = '0; release_offset = '0;
		mismatches = 0; recv_hold = 1'b0;
		send_idle_pct = 35; recv_idle_pct = 85;
		reg_start = REGION_START_RST;
		reg_bytes = REGION_BYTES_RST;
		heap_load();
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_tables_full();
		test_fragmented_free_full();
		test_region_settings();
		write_cfg(CFG_REGION_START, 16'd8);
		write_cfg(CFG_REGION_BYTES, 16'd65528);
		send_op(OP_REINIT, 16'd0, 16'd0);
		test_random(350);
		send_idle_pct = 85; recv_idle_pct = 35;
		write_cfg(CFG_REGION_START, 16'h1000);
		write_cfg(CFG_REGION_BYTES, 16'h3000);
		send_op(OP_REINIT, 16'd0, 16'd0);
		test_random(350);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_backpressure();
		write_cfg(CFG_REGION_START, 16'd8);
		write_cfg(CFG_REGION_BYTES, 16'd65528);
		send_op(OP_REINIT, 16'd0, 16'd0);
		test_random(350);

		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
